// ----- design/int_vector_fold_alu_macros.svh -----
// Assertion macros for the checker of the vector fold block.
// Depends on nothing; included by the checker only.
`ifndef INT_VECTOR_FOLD_ALU_MACROS_SVH
`define INT_VECTOR_FOLD_ALU_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define IVF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define IVF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- design/ivfa_pkg.sv -----
// Package for the vector fold block: operation codes, register indices, shared widths and unit request types.
// Depends on nothing.
package ivfa_pkg;
  localparam int unsigned DataW = 64;
  localparam int unsigned PosW  = 6;
  localparam logic [2:0] OpSum  = 3'd0;
  localparam logic [2:0] OpDiff = 3'd1;
  localparam logic [2:0] OpProd = 3'd2;
  localparam logic [2:0] OpQuot = 3'd3;
  localparam logic [2:0] OpDot  = 3'd4;
  localparam logic [1:0] RegOp   = 2'd0;
  localparam logic [1:0] RegLen  = 2'd1;
  localparam logic [1:0] RegCnt  = 2'd2;
  localparam logic [1:0] RegBias = 2'd3;

  typedef enum logic [1:0] {
    UnitAdd,
    UnitMul,
    UnitDiv
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_req_t;
endpackage

// ----- design/ivfa_ram.sv -----
// Generic single-port RAM with registered read.
// Depends on nothing.
module ivfa_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- design/ivfa_unit.sv -----
// Shared iterative arithmetic unit: registered add, shift-add multiply and
// restoring signed divide, one bit per cycle. Depends on ivfa_pkg.
module ivfa_unit import ivfa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  unit_req_t        req_i,
  input  logic [DataW-1:0] a_i,
  input  logic [DataW-1:0] b_i,
  output logic             done_o,
  output logic [DataW-1:0] res_o
);
  logic             busy_q, busy_d;
  unit_op_e         op_q, op_d;
  logic [6:0]       cnt_q, cnt_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic [DataW-1:0] mc_q, mc_d;
  logic [DataW-1:0] mp_q, mp_d;
  logic             neg_q, neg_d;
  logic             done_d;
  logic [DataW-1:0] res_d;
  logic [DataW:0]   trial;
  logic [DataW-1:0] rem_sh;

  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    res_d  = res_o;
    rem_sh = {acc_q[DataW-2:0], mp_q[DataW-1]};
    trial  = {1'b0, rem_sh} - {1'b0, mc_q};
    if (req_i.start) begin
      op_d  = req_i.op;
      cnt_d = 7'd0;
      unique case (req_i.op)
        UnitAdd: begin
          res_d  = a_i + b_i;
          done_d = 1'b1;
        end
        UnitMul: begin
          busy_d = 1'b1;
          acc_d  = '0;
          mc_d   = a_i;
          mp_d   = b_i;
        end
        default: begin
          busy_d = 1'b1;
          acc_d  = '0;
          neg_d  = a_i[DataW-1] ^ b_i[DataW-1];
          mp_d   = a_i[DataW-1] ? -a_i : a_i;
          mc_d   = b_i[DataW-1] ? -b_i : b_i;
        end
      endcase
    end else if (busy_q) begin
      cnt_d = cnt_q + 7'd1;
      if (op_q == UnitMul) begin
        if (mp_q[0]) begin
          acc_d = acc_q + mc_q;
        end
        mc_d = {mc_q[DataW-2:0], 1'b0};
        mp_d = {1'b0, mp_q[DataW-1:1]};
      end else begin
        mp_d = {mp_q[DataW-2:0], ~trial[DataW]};
        acc_d = trial[DataW] ? rem_sh : trial[DataW-1:0];
      end
      if (cnt_q == 7'(DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (op_q == UnitMul) begin
          res_d = mp_q[0] ? acc_q + mc_q : acc_q;
        end else begin
          res_d = neg_q ? -mp_d : mp_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      op_q   <= UnitAdd;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_o <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
    neg_q <= neg_d;
    res_o <= res_d;
  end
endmodule

// ----- design/int_vector_fold_alu.sv -----
// Top level of the vector fold block: sequencer, partial store and output.
// Depends on ivfa_pkg, ivfa_unit and ivfa_ram.
//
// Channel  | Direction | Handshake           | Payload
// element  | in        | element_valid/ready | element_i
// result   | out       | result_valid/ready  | value, position, last, status
// config   | in        | cfg_we_i            | cfg_idx_i, cfg_data_i
//
// An item passes Read, Fold and Wait, then Bias on the last vector, and Emit;
// the block takes no new element until it is back in Idle. Sum, difference,
// a divide by zero and a first vector use the add of the shared unit; product,
// quotient and dot product wait on its bit-serial multiplier and divider.
// After reset the block is ready at once while no register write is pending;
// the partial store is never cleared. A waiting result holds the block until it is taken.
module int_vector_fold_alu import ivfa_pkg::*; #(
  parameter int unsigned MaxLength = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [DataW-1:0] cfg_data_i,
  input  logic             element_valid_i,
  output logic             element_ready_o,
  input  logic [DataW-1:0] element_i,
  output logic             result_valid_o,
  input  logic             result_ready_i,
  output logic [DataW-1:0] value_o,
  output logic [PosW-1:0]  position_o,
  output logic             last_o,
  output logic             status_o
);
  localparam int unsigned AddrW = (MaxLength > 1) ? $clog2(MaxLength) : 1;
  localparam int unsigned LenW  = $clog2(MaxLength + 1);

  typedef enum logic [2:0] {
    Idle, Read, Fold, Wait, Bias, Emit
  } state_e;

  state_e           state_q;
  logic [2:0]       op_q;
  logic [6:0]       len_q;
  logic [7:0]       cnt_q;
  logic [DataW-1:0] bias_q;
  logic [AddrW-1:0] elem_q;
  logic [7:0]       vec_q;
  logic [DataW-1:0] dot_q;
  logic             err_q;
  logic [DataW-1:0] x_q;
  logic [DataW-1:0] acc_q;
  logic             ram_we;
  logic [DataW-1:0] ram_rdata;
  unit_req_t        ureq;
  logic [DataW-1:0] ua, ub, ures;
  logic             udone;
  logic [LenW-1:0]  len_eff;
  logic [7:0]       cnt_eff;
  logic             first_vec, final_vec, final_elem, is_dot;
  logic             sub_bias, add_bias;

  always_comb begin
    if (len_q == 7'd0) begin
      len_eff = LenW'(1);
    end else if ({25'd0, len_q} > 32'(MaxLength)) begin
      len_eff = LenW'(MaxLength);
    end else begin
      len_eff = LenW'(len_q);
    end
  end
  assign cnt_eff    = (cnt_q == 8'd0) ? 8'd1 : cnt_q;
  assign first_vec  = vec_q == 8'd0;
  assign final_vec  = vec_q == cnt_eff - 8'd1;
  assign final_elem = LenW'(elem_q) == len_eff - LenW'(1);
  assign is_dot     = op_q == OpDot;
  assign sub_bias   = op_q == OpDiff;
  assign add_bias   = (op_q != OpDiff) && (op_q != OpProd) && (op_q != OpQuot)
                      && !is_dot;
  assign ram_we     = (state_q == Wait) && udone;
  assign element_ready_o = (state_q == Idle) && !cfg_we_i;

  ivfa_ram #(.Width(DataW), .Depth(MaxLength)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (elem_q),
    .wdata_i(ures),
    .rdata_o(ram_rdata)
  );

  ivfa_unit u_unit (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (ureq),
    .a_i   (ua),
    .b_i   (ub),
    .done_o(udone),
    .res_o (ures)
  );

  always_comb begin
    ureq.start = 1'b0;
    ureq.op    = UnitAdd;
    ua         = ram_rdata;
    ub         = x_q;
    if (state_q == Fold) begin
      ureq.start = 1'b1;
      if (first_vec) begin
        ua = '0;
      end else begin
        unique case (op_q)
          OpDiff: ub = -x_q;
          OpProd, OpDot: ureq.op = UnitMul;
          OpQuot: ureq.op = (x_q == '0) ? UnitAdd : UnitDiv;
          default: ureq.op = UnitAdd;
        endcase
        if (op_q == OpQuot && x_q == '0) begin
          ub = '0;
        end
      end
    end else if (state_q == Bias) begin
      ureq.start = 1'b1;
      ua = acc_q;
      if (is_dot) begin
        ub = dot_q;
      end else begin
        ub = sub_bias ? -bias_q : (add_bias ? bias_q : '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= Idle;
      op_q           <= OpSum;
      len_q          <= 7'd64;
      cnt_q          <= 8'd2;
      bias_q         <= '0;
      elem_q         <= '0;
      vec_q          <= '0;
      dot_q          <= '0;
      err_q          <= 1'b0;
      result_valid_o <= 1'b0;
      status_o       <= 1'b0;
      last_o         <= 1'b0;
      position_o     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegOp:   op_q   <= cfg_data_i[2:0];
        RegLen:  len_q  <= cfg_data_i[6:0];
        RegCnt:  cnt_q  <= cfg_data_i[7:0];
        default: bias_q <= cfg_data_i;
      endcase
      elem_q <= '0;
      vec_q  <= '0;
      dot_q  <= '0;
      err_q  <= 1'b0;
    end else begin
      unique case (state_q)
        Idle: begin
          if (element_valid_i) begin
            if (LenW'(elem_q) >= len_eff) begin
              elem_q <= '0;
            end
            if (vec_q >= cnt_eff) begin
              vec_q <= '0;
            end
            state_q <= Read;
          end
        end
        Read: state_q <= Fold;
        Fold: begin
          if (!first_vec && op_q == OpQuot && x_q == '0) begin
            err_q <= 1'b1;
          end
          state_q <= Wait;
        end
        Wait: begin
          if (udone) begin
            if (final_vec) begin
              state_q <= Bias;
            end else begin
              state_q <= Emit;
            end
          end
        end
        Bias: begin
          if (is_dot) begin
            dot_q <= dot_q + acc_q;
          end
          state_q <= Emit;
        end
        default: begin
          if (result_valid_o) begin
            if (result_ready_i) begin
              result_valid_o <= 1'b0;
            end
          end else if (udone && final_vec && !(is_dot && !final_elem)) begin
            result_valid_o <= 1'b1;
            status_o       <= err_q;
            last_o         <= final_elem;
            position_o     <= is_dot ? '0 : PosW'(elem_q);
          end else begin
            state_q <= Idle;
            if (final_elem) begin
              elem_q <= '0;
              if (final_vec) begin
                vec_q <= '0;
                dot_q <= '0;
                err_q <= 1'b0;
              end else begin
                vec_q <= vec_q + 8'd1;
              end
            end else begin
              elem_q <= elem_q + AddrW'(1);
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (element_ready_o && element_valid_i) begin
      x_q <= element_i;
    end
    if (state_q == Wait && udone) begin
      acc_q <= ures;
    end
    if (state_q == Emit && !result_valid_o && udone) begin
      value_o <= ures;
    end
  end
endmodule

// ----- design/ivfa_checker.sv -----
// Port-level checker for the vector fold block, bound to the top level.
// Depends on int_vector_fold_alu_macros.svh.
`include "int_vector_fold_alu_macros.svh"
module ivfa_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       element_ready_o,
  input logic       element_valid_i,
  input logic       result_valid_o,
  input logic       result_ready_i,
  input logic [5:0] position_o,
  input logic       last_o,
  input logic       status_o
);
  `IVF_ASSERT_NEXT(a_no_take_twice, clk_i, rst_ni, element_valid_i && element_ready_o, !element_ready_o)
  `IVF_ASSERT_IMPL(a_busy_on_result, clk_i, rst_ni, result_valid_o, !element_ready_o)
  `IVF_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, result_valid_o && !result_ready_i, result_valid_o && $stable(position_o) && $stable(last_o) && $stable(status_o))
endmodule

bind int_vector_fold_alu ivfa_checker u_ivfa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .element_ready_o(element_ready_o),
  .element_valid_i(element_valid_i),
  .result_valid_o (result_valid_o),
  .result_ready_i (result_ready_i),
  .position_o     (position_o),
  .last_o         (last_o),
  .status_o       (status_o)
);

// ----- verif/int_vector_fold_alu_test.sv -----
// Self-checking testbench for int_vector_fold_alu: directed and random element
// streams, checked against a behavioral fold predictor. Depends on ivfa_pkg and int_vector_fold_alu.
`timescale 1ns / 1ps

module int_vector_fold_alu_test;
  import ivfa_pkg::*;

  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal = 64'h7fff_ffff_ffff_ffff;
  localparam logic [2:0]  OpSpare = 3'd7;
  localparam int unsigned RandItems = 1400;
  localparam int unsigned SettleCycles = 100;
  localparam longint unsigned CycleLimit = 800000;

  typedef struct packed {
    logic [63:0] value;
    logic [5:0]  position;
    logic        last;
    logic        status;
  } fold_res_t;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  idx;
    logic [63:0] data;
    logic        typed;
    logic [63:0] want;
  } stim_row_t;

  localparam int NumRows = 33;
  localparam stim_row_t DirRows [NumRows] = '{
    '{1'b1, RegLen,  64'd1,        1'b0, 64'd0},
    '{1'b1, RegCnt,  64'd1,        1'b0, 64'd0},
    '{1'b0, 2'd0,    MaxVal,       1'b1, MaxVal},
    '{1'b0, 2'd0,    MinVal,       1'b1, MinVal},
    '{1'b1, RegBias, 64'd1,        1'b0, 64'd0},
    '{1'b0, 2'd0,    MaxVal,       1'b1, MinVal},
    '{1'b1, RegBias, 64'd0,        1'b0, 64'd0},
    '{1'b1, RegOp,   64'(OpDiff),  1'b0, 64'd0},
    '{1'b1, RegCnt,  64'd2,        1'b0, 64'd0},
    '{1'b0, 2'd0,    64'd5,        1'b0, 64'd0},
    '{1'b0, 2'd0,    64'd3,        1'b0, 64'd0},
    '{1'b1, RegOp,   64'(OpProd),  1'b0, 64'd0},
    '{1'b0, 2'd0,    MinVal,       1'b0, 64'd0},
    '{1'b0, 2'd0,    '1,           1'b0, 64'd0},
    '{1'b1, RegOp,   64'(OpQuot),  1'b0, 64'd0},
    '{1'b0, 2'd0,    MinVal,       1'b0, 64'd0},
    '{1'b0, 2'd0,    '1,           1'b1, MinVal},
    '{1'b1, RegCnt,  64'd3,        1'b0, 64'd0},
    '{1'b0, 2'd0,    64'd10,       1'b0, 64'd0},
    '{1'b0, 2'd0,    64'd0,        1'b0, 64'd0},
    '{1'b0, 2'd0,    64'd3,        1'b0, 64'd0},
    '{1'b1, RegOp,   64'(OpDot),   1'b0, 64'd0},
    '{1'b1, RegLen,  64'd2,        1'b0, 64'd0},
    '{1'b1, RegCnt,  64'd2,        1'b0, 64'd0},
    '{1'b0, 2'd0,    64'd1,        1'b0, 64'd0},
    '{1'b0, 2'd0,    64'd2,        1'b0, 64'd0},
    '{1'b0, 2'd0,    64'd3,        1'b0, 64'd0},
    '{1'b0, 2'd0,    64'd4,        1'b0, 64'd0},
    '{1'b1, RegOp,   64'(OpSpare), 1'b0, 64'd0},
    '{1'b1, RegBias, -64'sd2,      1'b0, 64'd0},
    '{1'b1, RegLen,  64'd0,        1'b0, 64'd0},
    '{1'b1, RegCnt,  64'd0,        1'b0, 64'd0},
    '{1'b0, 2'd0,    64'd9,        1'b0, 64'd0}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_idx_i = '0;
  logic [DataW-1:0] cfg_data_i = '0;
  logic             element_valid_i = 1'b0;
  logic             element_ready_o;
  logic [DataW-1:0] element_i = '0;
  logic             result_valid_o;
  logic             result_ready_i = 1'b0;
  logic [DataW-1:0] value_o;
  logic [PosW-1:0]  position_o;
  logic             last_o;
  logic             status_o;

  int_vector_fold_alu u_top (.*);

  always #10 clk_i = ~clk_i;

  // Predictor state.
  logic [2:0]  fold_op = OpSum;
  logic [6:0]  fold_len = 7'd64;
  logic [7:0]  fold_cnt = 8'd2;
  logic [63:0] fold_bias = '0;
  logic [63:0] partial_mem [64];
  int          elem_idx = 0;
  int          vec_idx = 0;
  logic [63:0] dot_sum = '0;
  logic        div_err = 1'b0;

  fold_res_t   expected_q [$];
  int          fails = 0;
  bit          quiet = 1'b0;
  bit          hold_now = 1'b0;
  bit          in_flight = 1'b0;
  longint unsigned cycles = 0;

  function automatic logic [63:0] div_trunc(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic void restart_run();
    elem_idx = 0;
    vec_idx = 0;
    dot_sum = '0;
    div_err = 1'b0;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [63:0] data);
    case (idx)
      RegOp:   fold_op = data[2:0];
      RegLen:  fold_len = data[6:0];
      RegCnt:  fold_cnt = data[7:0];
      default: fold_bias = data;
    endcase
    restart_run();
  endfunction

  function automatic bit fold_element(logic [63:0] x, output fold_res_t r);
    int len, cnt;
    bit first, final_vec, final_elem, got;
    logic [63:0] acc;
    len = (fold_len == 0) ? 1 : (fold_len > 64 ? 64 : int'(fold_len));
    cnt = (fold_cnt == 0) ? 1 : int'(fold_cnt);
    if (elem_idx >= len) elem_idx = 0;
    if (vec_idx >= cnt) vec_idx = 0;
    first = (vec_idx == 0);
    final_vec = (vec_idx == cnt - 1);
    final_elem = (elem_idx == len - 1);
    got = 1'b0;
    r = '0;
    acc = first ? 64'd0 : partial_mem[elem_idx];
    case (fold_op)
      OpDiff: acc = first ? x : acc - x;
      OpProd, OpDot: acc = first ? x : acc * x;
      OpQuot: begin
        if (first) acc = x;
        else if (x == 0) div_err = 1'b1;
        else acc = div_trunc(acc, x);
      end
      default: acc = acc + x;
    endcase
    partial_mem[elem_idx] = acc;
    if (final_vec) begin
      if (fold_op == OpDot) begin
        dot_sum = dot_sum + acc;
        if (final_elem) begin
          r = '{dot_sum, 6'd0, 1'b1, div_err};
          got = 1'b1;
        end
      end else begin
        if (fold_op == OpDiff) acc = acc - fold_bias;
        else if (fold_op != OpProd && fold_op != OpQuot) acc = acc + fold_bias;
        r = '{acc, elem_idx[5:0], final_elem, div_err};
        got = 1'b1;
      end
    end
    elem_idx++;
    if (elem_idx >= len) begin
      elem_idx = 0;
      vec_idx++;
      if (vec_idx >= cnt) restart_run();
    end
    return got;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    fails++;
  endtask

  // Writes only once the block has drained; an item with no result may still be in work.
  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    if (in_flight) begin
      element_valid_i <= 1'b0;
      while (expected_q.size() != 0) @(posedge clk_i);
      repeat (SettleCycles) @(posedge clk_i);
      in_flight = 1'b0;
    end
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
  endtask

  task automatic send_element(logic [63:0] x, bit typed, logic [63:0] want);
    fold_res_t r;
    cfg_we_i <= 1'b0;
    element_valid_i <= 1'b1;
    element_i <= x;
    do @(posedge clk_i); while (!element_ready_o);
    in_flight = 1'b1;
    if (fold_element(x, r)) begin
      if (typed) r = '{want, 6'd0, 1'b1, 1'b0};
      expected_q.push_back(r);
    end
    if (!quiet && $urandom_range(99) < 24) begin
      element_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] pick_element();
    case ($urandom_range(9))
      0: return MinVal;
      1: return MaxVal;
      2, 3, 4: return 64'($signed($urandom_range(6)) - 3);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] noise_high();
    return ($urandom_range(7) == 0) ? {$urandom, $urandom} : 64'd0;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    fold_res_t exp_r;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (result_valid_o && result_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", value_o, 64'd0);
        end else begin
          exp_r = expected_q.pop_front();
          if (value_o !== exp_r.value) report_mismatch("value", value_o, exp_r.value);
          if (position_o !== exp_r.position)
            report_mismatch("position", 64'(position_o), 64'(exp_r.position));
          if (last_o !== exp_r.last) report_mismatch("last", 64'(last_o), 64'(exp_r.last));
          if (status_o !== exp_r.status)
            report_mismatch("status", 64'(status_o), 64'(exp_r.status));
        end
      end
      if (hold_now && !held) begin
        held = 1'b1;
        result_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        result_ready_i <= 1'b1;
      end else begin
        result_ready_i <= quiet || ($urandom_range(99) >= 24);
      end
    end
  end

  initial begin
    int sent, total, len, cnt;
    logic [2:0] op;
    logic [63:0] noise;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int k = 0; k < NumRows; k++) begin
      if (DirRows[k].is_cfg) write_reg(DirRows[k].idx, DirRows[k].data);
      else send_element(DirRows[k].data, DirRows[k].typed, DirRows[k].want);
    end
    write_reg(RegLen, 64'd127);
    send_element(64'd4, 1'b0, 64'd0);
    send_element(64'd5, 1'b0, 64'd0);

    sent = 0;
    while (sent < RandItems) begin
      op = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
      case ($urandom_range(19))
        0: len = 0;
        1: len = 64;
        2: len = $urandom_range(65, 127);
        default: len = $urandom_range(1, 8);
      endcase
      case ($urandom_range(39))
        0: cnt = 255;
        1, 2: cnt = 0;
        default: cnt = $urandom_range(1, 4);
      endcase
      if (cnt == 255) len = 1;
      noise = noise_high();
      write_reg(RegOp, {noise[63:3], op});
      noise = noise_high();
      write_reg(RegLen, {noise[63:7], 7'(len)});
      noise = noise_high();
      write_reg(RegCnt, {noise[63:8], 8'(cnt)});
      write_reg(RegBias, ($urandom_range(3) == 0) ? pick_element() : {$urandom, $urandom});
      len = (len == 0) ? 1 : (len > 64 ? 64 : len);
      cnt = (cnt == 0) ? 1 : cnt;
      total = len * cnt * $urandom_range(1, 3);
      if ($urandom_range(5) == 0) total = $urandom_range(1, total);
      for (int n = 0; n < total && sent < RandItems; n++) begin
        quiet = (sent >= 500 && sent < 700);
        if (sent == 900) hold_now = 1'b1;
        send_element(pick_element(), 1'b0, 64'd0);
        sent++;
      end
    end
    element_valid_i <= 1'b0;
    cfg_we_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
